// ===== sv/mbt_pkg.sv =====
// shared types, constants and helper functions for the mlp trainer
package mbt_pkg;

  localparam int DW     = 16;   // q4.12 data word
  localparam int AW     = 32;   // delta and gradient word
  localparam int MAW    = 41;   // shared multiplier, first operand
  localparam int MBW    = 17;   // shared multiplier, second operand
  localparam int PW     = MAW + MBW;
  localparam int FRAC   = 12;
  localparam int NMAX   = 8;
  localparam int LMAX   = 4;
  localparam int SLOTS  = NMAX + 1;
  localparam int WDEPTH = LMAX * NMAX * SLOTS;
  localparam int UDEPTH = LMAX * NMAX;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int UAW    = $clog2(UDEPTH);

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [PW-1:0] prod_t;

  // command codes
  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_INPUT  = 2'd1;
  localparam logic [1:0] CMD_TARGET = 2'd2;
  localparam logic [1:0] CMD_UPDATE = 2'd3;

  // register indexes
  localparam logic [2:0] REG_LAYERS = 3'd0;
  localparam logic [2:0] REG_INPUTS = 3'd1;
  localparam logic [2:0] REG_WIDTH0 = 3'd2;
  localparam logic [2:0] REG_WIDTH1 = 3'd3;
  localparam logic [2:0] REG_WIDTH2 = 3'd4;
  localparam logic [2:0] REG_WIDTH3 = 3'd5;
  localparam logic [2:0] REG_RATE   = 3'd6;
  localparam logic [2:0] REG_GAIN   = 3'd7;

  localparam prod_t DMAX = prod_t'({1'b0, {(DW-1){1'b1}}});
  localparam prod_t DMIN = -DMAX - prod_t'(1);
  localparam prod_t AMAX = prod_t'({1'b0, {(AW-1){1'b1}}});
  localparam prod_t AMIN = -AMAX - prod_t'(1);

  // bipolar sigmoid samples at steps of one quarter
  function automatic logic [11:0] sig_tab(input logic [5:0] k);
    logic [11:0] r;
    case (k)
      6'd0:  r = 12'd0;    6'd1:  r = 12'd509;  6'd2:  r = 12'd1003;
      6'd3:  r = 12'd1468; 6'd4:  r = 12'd1893; 6'd5:  r = 12'd2272;
      6'd6:  r = 12'd2602; 6'd7:  r = 12'd2883; 6'd8:  r = 12'd3119;
      6'd9:  r = 12'd3315; 6'd10: r = 12'd3475; 6'd11: r = 12'd3604;
      6'd12: r = 12'd3707; 6'd13: r = 12'd3790; 6'd14: r = 12'd3856;
      6'd15: r = 12'd3908; 6'd16: r = 12'd3949; 6'd17: r = 12'd3981;
      6'd18: r = 12'd4006; 6'd19: r = 12'd4026; 6'd20: r = 12'd4041;
      6'd21: r = 12'd4053; 6'd22: r = 12'd4063; 6'd23: r = 12'd4070;
      6'd24: r = 12'd4076; 6'd25: r = 12'd4080; 6'd26: r = 12'd4084;
      6'd27: r = 12'd4086; 6'd28: r = 12'd4089; 6'd29: r = 12'd4090;
      6'd30: r = 12'd4091; 6'd31: r = 12'd4092;
      default: r = 12'd4093;
    endcase
    return r;
  endfunction

  // zero counts as one, anything above the limit as the limit
  function automatic logic [3:0] clamp_cnt(input logic [3:0] v, input logic [3:0] hi);
    logic [3:0] r;
    if (v == 4'd0) r = 4'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic data_t sat_data(input prod_t v);
    data_t r;
    if (v > DMAX) r = data_t'(DMAX);
    else if (v < DMIN) r = data_t'(DMIN);
    else r = data_t'(v);
    return r;
  endfunction

  function automatic acc_t sat_acc(input prod_t v);
    acc_t r;
    if (v > AMAX) r = acc_t'(AMAX);
    else if (v < AMIN) r = acc_t'(AMIN);
    else r = acc_t'(v);
    return r;
  endfunction

endpackage

// ===== sv/mlp_backprop_trainer_unit.sv =====
// mlp trainer top level: sequencer, shared multiplier and weight, gradient, activation, delta stores
//
// A small q4.12 perceptron with up to four layers of eight neurons. The forward pass, backpropagation
// and updates go through one shared 41x17 multiplier under a sequencer, one operation at a time,
// and in_ready is low until the item is finished. A weight write and an input element without
// vec_last are taken in the idle state; the last element runs the forward pass, a product
// per weight after the bias and then a sigmoid step per neuron, then shows each output-layer
// result and waits on out_ready. A last target element runs backpropagation: a delta per
// neuron from the target or from the weights and deltas of the layer above, then the
// gradients for each weight and bias. An update walks all 288 weight slots. After reset the
// block clears all 288 slots of the weight and gradient memories before it takes the first
// item; configuration writes are taken in every cycle.
module mlp_backprop_trainer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    cmd,
  input  logic [1:0]    layer_sel,
  input  logic [2:0]    neuron_sel,
  input  logic [3:0]    elem_index,
  input  mbt_pkg::data_t value,
  input  logic          vec_last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_index,
  output mbt_pkg::data_t out_value,
  output logic          out_last
);
  import mbt_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_FBRD  = 5'd2;
  localparam logic [4:0] S_FBIAS = 5'd3;
  localparam logic [4:0] S_FRD   = 5'd4;
  localparam logic [4:0] S_FMUL  = 5'd5;
  localparam logic [4:0] S_FACC  = 5'd6;
  localparam logic [4:0] S_FNET  = 5'd7;
  localparam logic [4:0] S_FSIG  = 5'd8;
  localparam logic [4:0] S_FACT  = 5'd9;
  localparam logic [4:0] S_ERD   = 5'd10;
  localparam logic [4:0] S_ELD   = 5'd11;
  localparam logic [4:0] S_EW    = 5'd12;
  localparam logic [4:0] S_BYRD  = 5'd13;
  localparam logic [4:0] S_BYSQ  = 5'd14;
  localparam logic [4:0] S_BOM   = 5'd15;
  localparam logic [4:0] S_BTOP  = 5'd16;
  localparam logic [4:0] S_BDRD  = 5'd17;
  localparam logic [4:0] S_BDMUL = 5'd18;
  localparam logic [4:0] S_BDACC = 5'd19;
  localparam logic [4:0] S_BLOW  = 5'd20;
  localparam logic [4:0] S_BDST  = 5'd21;
  localparam logic [4:0] S_GRD   = 5'd22;
  localparam logic [4:0] S_GM1   = 5'd23;
  localparam logic [4:0] S_GM2   = 5'd24;
  localparam logic [4:0] S_GM3   = 5'd25;
  localparam logic [4:0] S_URD   = 5'd26;
  localparam logic [4:0] S_UM    = 5'd27;
  localparam logic [4:0] S_UWR   = 5'd28;

  localparam logic [3:0] BIAS = 4'(NMAX);

  // configuration registers
  logic [2:0]  layer_count;
  logic [3:0]  input_count, width_first, width_second, width_third, width_fourth;
  logic [14:0] learning_rate, update_gain;

  // sequencer state and counters
  logic [4:0]     state;
  logic [1:0]     j;
  logic [2:0]     i, k;
  logic [3:0]     h;
  logic [WAW-1:0] q;
  logic signed [39:0] facc;
  logic signed [51:0] dy;
  data_t          net, yreg;
  logic           sig_neg;
  logic [11:0]    sig_base;
  logic signed [MBW-1:0] om;
  prod_t          prod;
  data_t          inp [NMAX];
  data_t          tgt [NMAX];

  // memories
  data_t wmem [WDEPTH];
  acc_t  gmem [WDEPTH];
  data_t amem [UDEPTH];
  acc_t  dmem [UDEPTH];
  data_t wrd, ard;
  acc_t  grd, drd;
  logic           w_we, g_we, a_we, d_we;
  logic [WAW-1:0] w_waddr, g_waddr, w_raddr, g_raddr;
  logic [UAW-1:0] a_waddr, d_waddr, a_raddr, d_raddr;
  data_t          w_wdata, a_wdata;
  acc_t           g_wdata, d_wdata;

  // derived counts and datapath signals
  logic [3:0] lyr_n, n_cur, n_up, m_cur;
  logic       is_top;
  data_t      src;
  logic signed [MAW-1:0] ma;
  logic signed [MBW-1:0] mb;
  logic signed [16:0] net_x, ty;
  logic [16:0] abs_a;
  logic [6:0]  sk;
  logic [5:0]  tk;
  logic        sig_hi;
  logic [11:0] tab_lo, tab_diff;
  logic [12:0] sig_r;
  data_t       sig_rx, act;
  prod_t       om_full;

  function automatic logic [WAW-1:0] widx(input logic [1:0] jj, input logic [2:0] ii,
                                          input logic [3:0] hh);
    logic [WAW-1:0] u;
    u = WAW'({jj, ii});
    return (u << 3) + u + WAW'(hh);
  endfunction

  function automatic logic [3:0] width_of(input logic [1:0] jj);
    logic [3:0] w;
    case (jj)
      2'd0:    w = width_first;
      2'd1:    w = width_second;
      2'd2:    w = width_third;
      default: w = width_fourth;
    endcase
    return clamp_cnt(w, 4'(NMAX));
  endfunction

  // layer sizes seen by the sequencer
  always_comb begin
    lyr_n  = clamp_cnt({1'b0, layer_count}, 4'(LMAX));
    n_cur  = width_of(j);
    n_up   = width_of(j + 2'd1);
    m_cur  = (j == 2'd0) ? clamp_cnt(input_count, 4'(NMAX)) : width_of(j - 2'd1);
    is_top = ({2'b00, j} == lyr_n - 4'd1);
  end

  assign src    = (j == 2'd0) ? inp[h[2:0]] : ard;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count   <= 3'd2;
      input_count   <= 4'd2;
      width_first   <= 4'd4;
      width_second  <= 4'd1;
      width_third   <= 4'd1;
      width_fourth  <= 4'd1;
      learning_rate <= 15'd4096;
      update_gain   <= 15'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LAYERS: layer_count   <= cfg_data[2:0];
        REG_INPUTS: input_count   <= cfg_data[3:0];
        REG_WIDTH0: width_first   <= cfg_data[3:0];
        REG_WIDTH1: width_second  <= cfg_data[3:0];
        REG_WIDTH2: width_third   <= cfg_data[3:0];
        REG_WIDTH3: width_fourth  <= cfg_data[3:0];
        REG_RATE:   learning_rate <= cfg_data[14:0];
        REG_GAIN:   update_gain   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // input and target vector elements
  always_ff @(posedge clk) begin
    if (in_ready && in_valid && !elem_index[3]) begin
      if (cmd == CMD_INPUT) inp[elem_index[2:0]] <= value;
      if (cmd == CMD_TARGET) tgt[elem_index[2:0]] <= value;
    end
  end

  // sigmoid lookup and interpolation operands, output error and the one-minus-square term
  always_comb begin
    net_x    = 17'(net);
    abs_a    = (net_x < 0) ? 17'(-net_x) : 17'(net_x);
    sk       = abs_a[16:10];
    sig_hi   = sk[6] | sk[5];
    tk       = sk[5:0];
    tab_lo   = sig_tab(tk);
    tab_diff = sig_tab(tk + 6'd1) - tab_lo;
    sig_r    = {1'b0, sig_base} + 13'(prod >>> 10);
    sig_rx   = data_t'({3'b000, sig_r});
    act      = sig_neg ? -sig_rx : sig_rx;
    ty       = 17'(tgt[i]) - 17'(yreg);
    om_full  = prod_t'(1 << FRAC) - (prod >>> FRAC);
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_FMUL: begin
        ma = MAW'(src);
        mb = MBW'(wrd);
      end
      S_FSIG: begin
        ma = sig_hi ? '0 : MAW'({1'b0, tab_diff});
        mb = MBW'({1'b0, abs_a[9:0]});
      end
      S_BYSQ: begin
        ma = MAW'(ard);
        mb = MBW'(ard);
      end
      S_BTOP: begin
        ma = MAW'(ty);
        mb = om;
      end
      S_BDMUL: begin
        ma = MAW'(drd);
        mb = MBW'(wrd);
      end
      S_BLOW: begin
        ma = MAW'(dy >>> FRAC);
        mb = om;
      end
      S_GM1: begin
        ma = MAW'(drd);
        mb = (h == BIAS) ? MBW'({1'b0, learning_rate}) : MBW'(src);
      end
      S_GM2: begin
        ma = MAW'(prod >>> FRAC);
        mb = MBW'({1'b0, learning_rate});
      end
      S_UM: begin
        ma = MAW'(grd);
        mb = MBW'({1'b0, update_gain});
      end
      default: ;
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= PW'(ma) * PW'(mb);
  end

  // memory read addresses follow the counters
  always_comb begin
    case (state) inside
      S_BDRD, S_BDMUL: w_raddr = widx(j + 2'd1, k, {1'b0, i});
      S_URD, S_UM, S_UWR: w_raddr = q;
      default: w_raddr = widx(j, i, h);
    endcase
    case (state) inside
      S_URD, S_UM, S_UWR: g_raddr = q;
      default: g_raddr = widx(j, i, h);
    endcase
    case (state) inside
      S_BYRD, S_BYSQ, S_ERD, S_ELD: a_raddr = {j, i};
      default: a_raddr = {j - 2'd1, h[2:0]};
    endcase
    case (state) inside
      S_BDRD, S_BDMUL: d_raddr = {j + 2'd1, k};
      default: d_raddr = {j, i};
    endcase
  end

  // memory write ports
  always_comb begin
    w_we    = 1'b0;
    w_waddr = q;
    w_wdata = '0;
    g_we    = 1'b0;
    g_waddr = q;
    g_wdata = '0;
    case (state)
      S_IDLE: begin
        w_we    = in_valid && (cmd == CMD_WEIGHT) && (elem_index <= BIAS);
        w_waddr = widx(layer_sel, neuron_sel, elem_index);
        w_wdata = value;
      end
      S_CLR: begin
        w_we = 1'b1;
        g_we = 1'b1;
      end
      S_UWR: begin
        w_we    = 1'b1;
        w_wdata = sat_data(PW'(wrd) + (prod >>> FRAC));
        g_we    = 1'b1;
      end
      S_GM3: begin
        g_we    = 1'b1;
        g_waddr = widx(j, i, h);
        g_wdata = sat_acc(PW'(grd) + (prod >>> FRAC));
      end
      default: ;
    endcase
    a_we    = (state == S_FACT);
    a_waddr = {j, i};
    a_wdata = act;
    d_we    = (state == S_BDST);
    d_waddr = {j, i};
    d_wdata = sat_acc(prod >>> (FRAC + 1));
  end

  // store arrays, registered read
  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    if (g_we) gmem[g_waddr] <= g_wdata;
    if (a_we) amem[a_waddr] <= a_wdata;
    if (d_we) dmem[d_waddr] <= d_wdata;
    wrd <= wmem[w_raddr];
    grd <= gmem[g_raddr];
    ard <= amem[a_raddr];
    drd <= dmem[d_raddr];
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      S_FBIAS: facc <= 40'(wrd) <<< FRAC;
      S_FACC:  facc <= facc + 40'(prod);
      S_FNET:  net <= sat_data(PW'(facc >>> FRAC));
      S_FSIG: begin
        sig_neg  <= net[DW-1];
        sig_base <= sig_hi ? sig_tab(6'd32) : tab_lo;
      end
      S_BYSQ:  yreg <= ard;
      S_BOM: begin
        om <= MBW'(om_full);
        dy <= '0;
      end
      S_BDACC: dy <= dy + 52'(prod);
      S_ELD: begin
        out_index <= i;
        out_value <= ard;
        out_last  <= ({1'b0, i} == n_cur - 4'd1);
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      q         <= '0;
      j         <= '0;
      i         <= '0;
      h         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (cmd)
              CMD_INPUT: begin
                if (vec_last) begin
                  j     <= '0;
                  i     <= '0;
                  h     <= BIAS;
                  state <= S_FBRD;
                end
              end
              CMD_TARGET: begin
                if (vec_last) begin
                  j     <= 2'(lyr_n - 4'd1);
                  i     <= '0;
                  state <= S_BYRD;
                end
              end
              CMD_UPDATE: begin
                q     <= '0;
                state <= S_URD;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          q <= q + 1'b1;
          if (q == WAW'(WDEPTH - 1)) state <= S_IDLE;
        end
        // forward pass
        S_FBRD: state <= S_FBIAS;
        S_FBIAS: begin
          h     <= '0;
          state <= S_FRD;
        end
        S_FRD:  state <= S_FMUL;
        S_FMUL: state <= S_FACC;
        S_FACC: begin
          if (h == m_cur - 4'd1) begin
            state <= S_FNET;
          end else begin
            h     <= h + 4'd1;
            state <= S_FRD;
          end
        end
        S_FNET: state <= S_FSIG;
        S_FSIG: state <= S_FACT;
        S_FACT: begin
          h <= BIAS;
          if ({1'b0, i} == n_cur - 4'd1) begin
            i <= '0;
            if (is_top) begin
              state <= S_ERD;
            end else begin
              j     <= j + 2'd1;
              state <= S_FBRD;
            end
          end else begin
            i     <= i + 3'd1;
            state <= S_FBRD;
          end
        end
        // result beats
        S_ERD: state <= S_ELD;
        S_ELD: begin
          out_valid <= 1'b1;
          state     <= S_EW;
        end
        S_EW: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 3'd1;
              state <= S_ERD;
            end
          end
        end
        // deltas, top layer down
        S_BYRD: state <= S_BYSQ;
        S_BYSQ: state <= S_BOM;
        S_BOM: begin
          k     <= '0;
          state <= is_top ? S_BTOP : S_BDRD;
        end
        S_BTOP:  state <= S_BDST;
        S_BDRD:  state <= S_BDMUL;
        S_BDMUL: state <= S_BDACC;
        S_BDACC: begin
          if ({1'b0, k} == n_up - 4'd1) begin
            state <= S_BLOW;
          end else begin
            k     <= k + 3'd1;
            state <= S_BDRD;
          end
        end
        S_BLOW: state <= S_BDST;
        S_BDST: begin
          if ({1'b0, i} == n_cur - 4'd1) begin
            i <= '0;
            if (j == 2'd0) begin
              h     <= '0;
              state <= S_GRD;
            end else begin
              j     <= j - 2'd1;
              state <= S_BYRD;
            end
          end else begin
            i     <= i + 3'd1;
            state <= S_BYRD;
          end
        end
        // gradient accumulation, bottom layer up
        S_GRD: state <= S_GM1;
        S_GM1: state <= (h == BIAS) ? S_GM3 : S_GM2;
        S_GM2: state <= S_GM3;
        S_GM3: begin
          state <= S_GRD;
          if (h == BIAS) begin
            h <= '0;
            if ({1'b0, i} == n_cur - 4'd1) begin
              i <= '0;
              if (is_top) state <= S_IDLE;
              else j <= j + 2'd1;
            end else begin
              i <= i + 3'd1;
            end
          end else if (h == m_cur - 4'd1) begin
            h <= BIAS;
          end else begin
            h <= h + 4'd1;
          end
        end
        // weight update sweep
        S_URD: state <= S_UM;
        S_UM:  state <= S_UWR;
        S_UWR: begin
          q <= q + 1'b1;
          state <= (q == WAW'(WDEPTH - 1)) ? S_IDLE : S_URD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/mbt_chk.sv =====
// port-level checker for the mlp trainer, bound to the top level
module mbt_chk (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic [2:0]     out_index,
  input mbt_pkg::data_t out_value,
  input logic           out_last
);
  import mbt_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index)
      && $stable(out_last))
    else $error("result beat changed while stalled");

  // no new item while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  // more results of the vector follow
  a_more_beats: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input taken before the last result beat");

  // memories are being cleared right after reset
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during clearing");

endmodule

bind mlp_backprop_trainer_unit mbt_chk u_mbt_chk (.*);
